>>> rtl/rth_pkg.sv
package rth_pkg;

    // channel widths and derived widths
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned QUOT_W  = 8;
    localparam int unsigned SECT_W  = 11;
    localparam int unsigned NUM_W   = 16;

    // hue scale: 30 steps per sector, six sectors
    localparam int unsigned HUE_MAX = 180;

    // which channel holds the maximum (red wins ties, then green)
    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

endpackage

>>> rtl/rgb_to_hsv_pixel.sv
// rgb to hsv pixel converter, hue on a 0..179 scale
// a request passes the input, max/min, sector, numerator, divider and output registers
// one pixel per clock unless stalled; 8 divider stages per quotient set the depth
// a stall on the output freezes every stage at once, nothing is dropped or repeated
// reset (synchronous, active low) clears the valid bits only
module rgb_to_hsv_pixel
    import rth_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PIX_W-1:0]  i_red,
    input  logic [PIX_W-1:0]  i_green,
    input  logic [PIX_W-1:0]  i_blue,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [QUOT_W-1:0] o_hue,
    output logic [QUOT_W-1:0] o_saturation,
    output logic [PIX_W-1:0]  o_brightness
);

    // global advance: the whole pipe holds while the output is stalled
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // stage 1: input registers
    logic             r_s1_v;
    logic [PIX_W-1:0] r_s1_r, r_s1_g, r_s1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= i_valid;
        end
        if (w_adv) begin
            r_s1_r <= i_red;
            r_s1_g <= i_green;
            r_s1_b <= i_blue;
        end
    end

    // stage 2: max, min, delta and the winning channel
    logic             r_s2_v;
    logic [PIX_W-1:0] r_s2_r, r_s2_g, r_s2_b, r_s2_mx, r_s2_d;
    t_chan            r_s2_sel;
    logic [PIX_W-1:0] n_s2_mx, n_s2_mn;
    t_chan            n_s2_sel;

    always_comb begin
        if (r_s1_r >= r_s1_g && r_s1_r >= r_s1_b) begin
            n_s2_sel = CH_RED;
            n_s2_mx  = r_s1_r;
        end else if (r_s1_g >= r_s1_b) begin
            n_s2_sel = CH_GREEN;
            n_s2_mx  = r_s1_g;
        end else begin
            n_s2_sel = CH_BLUE;
            n_s2_mx  = r_s1_b;
        end
        if (r_s1_r <= r_s1_g && r_s1_r <= r_s1_b) begin
            n_s2_mn = r_s1_r;
        end else if (r_s1_g <= r_s1_b) begin
            n_s2_mn = r_s1_g;
        end else begin
            n_s2_mn = r_s1_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_adv) begin
            r_s2_v <= r_s1_v;
        end
        if (w_adv) begin
            r_s2_r   <= r_s1_r;
            r_s2_g   <= r_s1_g;
            r_s2_b   <= r_s1_b;
            r_s2_mx  <= n_s2_mx;
            r_s2_d   <= n_s2_mx - n_s2_mn;
            r_s2_sel <= n_s2_sel;
        end
    end

    // stage 3: sector value times delta, and 255 * delta
    logic              r_s3_v;
    logic [SECT_W-1:0] r_s3_x;
    logic [NUM_W-1:0]  r_s3_snum;
    logic [PIX_W-1:0]  r_s3_mx, r_s3_d;
    logic [SECT_W-1:0] n_s3_x;
    logic [SECT_W-1:0] w_d_ext, w_r_ext, w_g_ext, w_b_ext;

    assign w_d_ext = {(SECT_W-PIX_W)'(0), r_s2_d};
    assign w_r_ext = {(SECT_W-PIX_W)'(0), r_s2_r};
    assign w_g_ext = {(SECT_W-PIX_W)'(0), r_s2_g};
    assign w_b_ext = {(SECT_W-PIX_W)'(0), r_s2_b};

    always_comb begin
        case (r_s2_sel)
            CH_RED: begin
                // negative sector value wraps by six sectors
                if (r_s2_g >= r_s2_b) begin
                    n_s3_x = w_g_ext - w_b_ext;
                end else begin
                    n_s3_x = (w_d_ext << 2) + (w_d_ext << 1) - (w_b_ext - w_g_ext);
                end
            end
            CH_GREEN: n_s3_x = (w_d_ext << 1) + w_b_ext - w_r_ext;
            CH_BLUE:  n_s3_x = (w_d_ext << 2) + w_r_ext - w_g_ext;
            default:  n_s3_x = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_adv) begin
            r_s3_v <= r_s2_v;
        end
        if (w_adv) begin
            r_s3_x    <= n_s3_x;
            r_s3_snum <= {r_s2_d, 8'h00} - {8'h00, r_s2_d};
            r_s3_mx   <= r_s2_mx;
            r_s3_d    <= r_s2_d;
        end
    end

    // stage 4 and divider stages share these arrays; index 0 holds the numerators
    logic              r_dv_v    [0:QUOT_W];
    logic [NUM_W-1:0]  r_dv_hrem [0:QUOT_W];
    logic [NUM_W-1:0]  r_dv_srem [0:QUOT_W];
    logic [QUOT_W-1:0] r_dv_hq   [0:QUOT_W];
    logic [QUOT_W-1:0] r_dv_sq   [0:QUOT_W];
    logic [PIX_W-1:0]  r_dv_mx   [0:QUOT_W];
    logic [PIX_W-1:0]  r_dv_d    [0:QUOT_W];

    // stage 4: hue numerator is 30 times the sector value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_v[0] <= r_s3_v;
        end
        if (w_adv) begin
            r_dv_hrem[0] <= {r_s3_x, 5'b00000} - {4'b0000, r_s3_x, 1'b0};
            r_dv_srem[0] <= r_s3_snum;
            r_dv_hq[0]   <= '0;
            r_dv_sq[0]   <= '0;
            r_dv_mx[0]   <= r_s3_mx;
            r_dv_d[0]    <= r_s3_d;
        end
    end

    // restoring dividers, one quotient bit per stage, msb first
    for (genvar k = 0; k < QUOT_W; k++) begin : g_div
        localparam int unsigned SH = QUOT_W - 1 - k;
        logic [NUM_W-1:0]  w_hdiv, w_sdiv;
        logic              w_hge, w_sge;
        logic [QUOT_W-1:0] n_hq, n_sq;

        assign w_hdiv = {(NUM_W-PIX_W)'(0), r_dv_d[k]} << SH;
        assign w_sdiv = {(NUM_W-PIX_W)'(0), r_dv_mx[k]} << SH;
        assign w_hge  = r_dv_hrem[k] >= w_hdiv;
        assign w_sge  = r_dv_srem[k] >= w_sdiv;

        always_comb begin
            n_hq     = r_dv_hq[k];
            n_sq     = r_dv_sq[k];
            n_hq[SH] = w_hge;
            n_sq[SH] = w_sge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            if (w_adv) begin
                r_dv_hrem[k+1] <= w_hge ? r_dv_hrem[k] - w_hdiv : r_dv_hrem[k];
                r_dv_srem[k+1] <= w_sge ? r_dv_srem[k] - w_sdiv : r_dv_srem[k];
                r_dv_hq[k+1]   <= n_hq;
                r_dv_sq[k+1]   <= n_sq;
                r_dv_mx[k+1]   <= r_dv_mx[k];
                r_dv_d[k+1]    <= r_dv_d[k];
            end
        end
    end

    // output register: grey pixels get zero hue, black pixels zero saturation
    logic              r_out_v;
    logic [QUOT_W-1:0] r_out_hue, r_out_sat;
    logic [PIX_W-1:0]  r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= r_dv_v[QUOT_W];
        end
        if (w_adv) begin
            r_out_hue <= (r_dv_d[QUOT_W] == '0) ? '0 : r_dv_hq[QUOT_W];
            r_out_sat <= (r_dv_mx[QUOT_W] == '0) ? '0 : r_dv_sq[QUOT_W];
            r_out_val <= r_dv_mx[QUOT_W];
        end
    end

    assign o_valid      = r_out_v;
    assign o_hue        = r_out_hue;
    assign o_saturation = r_out_sat;
    assign o_brightness = r_out_val;

    // hue stays on its 0..179 scale
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < QUOT_W'(HUE_MAX)))
        else $error("hue out of range");

    // zero saturation means a grey pixel, so hue must be zero too
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturation == '0) |-> (o_hue == '0))
        else $error("nonzero hue on grey pixel");

    // hue divider leaves a remainder below the delta
    a_hue_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[QUOT_W] && r_dv_d[QUOT_W] != '0) |->
            (r_dv_hrem[QUOT_W] < {(NUM_W-PIX_W)'(0), r_dv_d[QUOT_W]}))
        else $error("hue remainder not reduced");

    // saturation divider leaves a remainder below the maximum
    a_sat_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_v[QUOT_W] && r_dv_mx[QUOT_W] != '0) |->
            (r_dv_srem[QUOT_W] < {(NUM_W-PIX_W)'(0), r_dv_mx[QUOT_W]}))
        else $error("saturation remainder not reduced");

endmodule
